/* rtl/pdi_pkg.sv */
// ----------------------------------------------------------------------------
// pdi_pkg
// Types, constants and the micro-program of the deformation increment unit.
// ----------------------------------------------------------------------------
package pdi_pkg;

  localparam int PARTICLE_COUNT = 1024;
  localparam int IDX_W          = $clog2(PARTICLE_COUNT);
  localparam int IN_IDX_W       = 10;

  localparam int TMP_W    = 6;            // temporary register file address
  localparam int TMP_N    = 1 << TMP_W;
  localparam int PC_W     = 6;
  localparam logic [PC_W-1:0] PC_LAST = PC_W'(54);

  localparam logic signed [31:0] Q_ONE  = 32'sh0100_0000;
  localparam logic signed [31:0] Q_HALF = 32'sh0080_0000;
  localparam logic signed [31:0] Q_ZERO = 32'sh0000_0000;

  // fixed operand sources
  localparam logic [3:0] S_GXX  = 4'd0;
  localparam logic [3:0] S_GYY  = 4'd1;
  localparam logic [3:0] S_GXY  = 4'd2;
  localparam logic [3:0] S_GYX  = 4'd3;
  localparam logic [3:0] S_GZZ  = 4'd4;
  localparam logic [3:0] S_EXX  = 4'd5;
  localparam logic [3:0] S_EYY  = 4'd6;
  localparam logic [3:0] S_EZZ  = 4'd7;
  localparam logic [3:0] S_EXY  = 4'd8;
  localparam logic [3:0] S_WXY  = 4'd9;
  localparam logic [3:0] S_BXX  = 4'd10;
  localparam logic [3:0] S_BXY  = 4'd11;
  localparam logic [3:0] S_BYY  = 4'd12;
  localparam logic [3:0] S_BZZ  = 4'd13;
  localparam logic [3:0] S_HALF = 4'd14;
  localparam logic [3:0] S_ONE  = 4'd15;

  // temporaries that hold the final results
  localparam logic [TMP_W-1:0] T_NXX  = TMP_W'(14);
  localparam logic [TMP_W-1:0] T_NYY  = TMP_W'(23);
  localparam logic [TMP_W-1:0] T_NXY  = TMP_W'(24);
  localparam logic [TMP_W-1:0] T_NWXY = TMP_W'(25);
  localparam logic [TMP_W-1:0] T_NZZ  = TMP_W'(27);
  localparam logic [TMP_W-1:0] T_NBXX = TMP_W'(43);
  localparam logic [TMP_W-1:0] T_NBXY = TMP_W'(46);
  localparam logic [TMP_W-1:0] T_NBYY = TMP_W'(49);
  localparam logic [TMP_W-1:0] T_NBZZ = TMP_W'(50);
  localparam logic [TMP_W-1:0] T_DET  = TMP_W'(54);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } alu_op_t;

  // operand: tmp = 1 selects the register file, else a fixed source
  typedef struct packed {
    logic             tmp;
    logic [TMP_W-1:0] addr;
  } opnd_t;

  typedef struct packed {
    alu_op_t op;
    opnd_t   a;
    opnd_t   b;
  } uinstr_t;

  typedef struct packed {
    logic signed [31:0] exx;
    logic signed [31:0] eyy;
    logic signed [31:0] ezz;
    logic signed [31:0] exy;
    logic signed [31:0] wxy;
    logic signed [31:0] bxx;
    logic signed [31:0] bxy;
    logic signed [31:0] byy;
    logic signed [31:0] bzz;
  } pstate_t;

  function automatic opnd_t fx(input logic [3:0] s);
    opnd_t o;
    o.tmp  = 1'b0;
    o.addr = TMP_W'(s);
    return o;
  endfunction

  function automatic opnd_t tm(input int n);
    opnd_t o;
    o.tmp  = 1'b1;
    o.addr = TMP_W'(n);
    return o;
  endfunction

  function automatic uinstr_t mk(input alu_op_t op, input opnd_t a, input opnd_t b);
    uinstr_t u;
    u.op = op;
    u.a  = a;
    u.b  = b;
    return u;
  endfunction

  // Step n writes temporary n.
  function automatic uinstr_t ucode(input logic [PC_W-1:0] pc);
    uinstr_t u;
    u = mk(OP_ADD, fx(S_ONE), fx(S_GXX));
    case (pc)
      6'd0:  u = mk(OP_ADD, fx(S_ONE), fx(S_GXX));   // oxx
      6'd1:  u = mk(OP_ADD, fx(S_ONE), fx(S_GYY));   // oyy
      6'd2:  u = mk(OP_ADD, fx(S_ONE), fx(S_GZZ));   // ozz
      6'd3:  u = mk(OP_ADD, fx(S_ONE), fx(S_EXX));
      6'd4:  u = mk(OP_ADD, fx(S_ONE), fx(S_EYY));
      6'd5:  u = mk(OP_ADD, fx(S_ONE), fx(S_EZZ));
      6'd6:  u = mk(OP_ADD, fx(S_EXY), fx(S_WXY));
      6'd7:  u = mk(OP_MUL, fx(S_HALF), tm(6));      // pf10
      6'd8:  u = mk(OP_MUL, fx(S_GYX), tm(3));
      6'd9:  u = mk(OP_MUL, tm(1), tm(7));
      6'd10: u = mk(OP_ADD, tm(8), tm(9));           // f10
      6'd11: u = mk(OP_MUL, fx(S_GXX), tm(3));
      6'd12: u = mk(OP_MUL, fx(S_GXY), tm(7));
      6'd13: u = mk(OP_ADD, tm(11), tm(12));
      6'd14: u = mk(OP_ADD, fx(S_EXX), tm(13));      // nxx
      6'd15: u = mk(OP_SUB, fx(S_EXY), fx(S_WXY));
      6'd16: u = mk(OP_MUL, fx(S_HALF), tm(15));     // pf01
      6'd17: u = mk(OP_MUL, tm(0), tm(16));
      6'd18: u = mk(OP_MUL, fx(S_GXY), tm(4));
      6'd19: u = mk(OP_ADD, tm(17), tm(18));         // f01
      6'd20: u = mk(OP_MUL, fx(S_GYX), tm(16));
      6'd21: u = mk(OP_MUL, fx(S_GYY), tm(4));
      6'd22: u = mk(OP_ADD, tm(20), tm(21));
      6'd23: u = mk(OP_ADD, fx(S_EYY), tm(22));      // nyy
      6'd24: u = mk(OP_ADD, tm(10), tm(19));         // nxy
      6'd25: u = mk(OP_SUB, tm(10), tm(19));         // nwxy
      6'd26: u = mk(OP_MUL, fx(S_GZZ), tm(5));
      6'd27: u = mk(OP_ADD, fx(S_EZZ), tm(26));      // nzz
      6'd28: u = mk(OP_MUL, tm(0), fx(S_BXX));
      6'd29: u = mk(OP_MUL, fx(S_GXY), fx(S_BXY));
      6'd30: u = mk(OP_ADD, tm(28), tm(29));         // b1
      6'd31: u = mk(OP_MUL, tm(0), fx(S_BXY));
      6'd32: u = mk(OP_MUL, fx(S_GXY), fx(S_BYY));
      6'd33: u = mk(OP_ADD, tm(31), tm(32));         // b2
      6'd34: u = mk(OP_MUL, fx(S_GYX), fx(S_BXX));
      6'd35: u = mk(OP_MUL, tm(1), fx(S_BXY));
      6'd36: u = mk(OP_ADD, tm(34), tm(35));         // b3
      6'd37: u = mk(OP_MUL, fx(S_GYX), fx(S_BXY));
      6'd38: u = mk(OP_MUL, tm(1), fx(S_BYY));
      6'd39: u = mk(OP_ADD, tm(37), tm(38));         // b4
      6'd40: u = mk(OP_MUL, tm(2), fx(S_BZZ));       // b5
      6'd41: u = mk(OP_MUL, tm(30), tm(0));
      6'd42: u = mk(OP_MUL, tm(33), fx(S_GXY));
      6'd43: u = mk(OP_ADD, tm(41), tm(42));         // nbxx
      6'd44: u = mk(OP_MUL, tm(30), fx(S_GYX));
      6'd45: u = mk(OP_MUL, tm(33), tm(1));
      6'd46: u = mk(OP_ADD, tm(44), tm(45));         // nbxy
      6'd47: u = mk(OP_MUL, tm(36), fx(S_GYX));
      6'd48: u = mk(OP_MUL, tm(39), tm(1));
      6'd49: u = mk(OP_ADD, tm(47), tm(48));         // nbyy
      6'd50: u = mk(OP_MUL, tm(40), tm(2));          // nbzz
      6'd51: u = mk(OP_MUL, tm(0), tm(1));
      6'd52: u = mk(OP_MUL, fx(S_GYX), fx(S_GXY));
      6'd53: u = mk(OP_SUB, tm(51), tm(52));
      6'd54: u = mk(OP_MUL, tm(2), tm(53));          // det
      default: u = mk(OP_ADD, fx(S_ONE), fx(S_GXX));
    endcase
    return u;
  endfunction

endpackage

/* rtl/particle_deformation_increment.sv */
// ----------------------------------------------------------------------------
// particle_deformation_increment
// Finite strain update of one particle's 2D/axisymmetric deformation state.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block reads the
// particle's strain, rotation and B tensor, runs a 55-step micro-program on
// one shared saturating Q8.24 unit (add, subtract or 32x32 rounded multiply),
// writes the new state back and shows the result for one cycle with
// out_valid. The receiver cannot stall: it must take the result in that
// cycle. Each request runs the state read, then operand read, execute and
// write back for every step on the shared unit, then the state write. busy
// is high from acceptance until out_valid, so a new request may be given
// in the cycle out_valid is shown. After reset the state store is cleared
// to the undeformed state, one particle per cycle, and busy stays high
// until all PARTICLE_COUNT (1024) particles are cleared.
// Particle index is taken modulo PARTICLE_COUNT.
// ----------------------------------------------------------------------------
module particle_deformation_increment (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [pdi_pkg::IN_IDX_W-1:0]       in_particle_index,
  input  logic signed [31:0]                 in_grad_xx,
  input  logic signed [31:0]                 in_grad_yy,
  input  logic signed [31:0]                 in_grad_xy,
  input  logic signed [31:0]                 in_grad_yx,
  input  logic signed [31:0]                 in_grad_zz,
  output logic                               out_valid,
  output logic signed [31:0]                 out_new_strain_xx,
  output logic signed [31:0]                 out_new_strain_yy,
  output logic signed [31:0]                 out_new_strain_zz,
  output logic signed [31:0]                 out_new_shear_xy,
  output logic signed [31:0]                 out_new_rotation_xy,
  output logic signed [31:0]                 out_new_b_xx,
  output logic signed [31:0]                 out_new_b_xy,
  output logic signed [31:0]                 out_new_b_yy,
  output logic signed [31:0]                 out_new_b_zz,
  output logic signed [31:0]                 out_increment_det
);

  // one-hot sequencer states
  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,  // clearing pass after reset
    ST_IDLE  = 7'b0000010,
    ST_FETCH = 7'b0000100,  // state store read
    ST_OPRD  = 7'b0001000,  // operand read
    ST_EXEC  = 7'b0010000,  // shared unit
    ST_WRB   = 7'b0100000,  // temporary write back
    ST_STORE = 7'b1000000   // state write back, result out
  } seq_state_t;

  seq_state_t                    state_r, state_nxt;
  logic [pdi_pkg::IDX_W-1:0]     clr_cnt_r;
  logic [pdi_pkg::IDX_W-1:0]     idx_r;
  logic [pdi_pkg::PC_W-1:0]      pc_r;
  logic                          out_valid_r;

  // input gradient terms of the current request
  logic signed [31:0] gxx_r, gyy_r, gxy_r, gyx_r, gzz_r;

  // per-particle state store and its read register
  pdi_pkg::pstate_t   st_mem [pdi_pkg::PARTICLE_COUNT];
  pdi_pkg::pstate_t   st_rd_r;
  pdi_pkg::pstate_t   st_wdata;
  pdi_pkg::pstate_t   st_clear;
  logic               st_we;
  logic [pdi_pkg::IDX_W-1:0] st_waddr;

  // temporary register file, two read ports
  logic signed [31:0] tmp_mem [pdi_pkg::TMP_N];
  logic signed [31:0] ta_r, tb_r;     // register file read data
  logic signed [31:0] fa_r, fb_r;     // fixed source data
  logic               sel_a_r, sel_b_r;
  pdi_pkg::alu_op_t   op_r;
  logic signed [31:0] res_r, res_nxt;

  pdi_pkg::uinstr_t   uin;
  logic signed [31:0] fa_nxt, fb_nxt;
  logic signed [31:0] opa, opb;

  // result registers, captured as the final temporaries are written
  logic signed [31:0] nxx_r, nyy_r, nzz_r, nxy_r, nwxy_r;
  logic signed [31:0] nbxx_r, nbxy_r, nbyy_r, nbzz_r, det_r;

  // ALU internals
  logic signed [63:0] prod;
  logic signed [63:0] prod_rnd;
  logic signed [63:0] prod_q;
  logic signed [32:0] sum;

  assign uin = pdi_pkg::ucode(pc_r);

  function automatic logic signed [31:0] fixed_src(
    input logic [3:0]         s,
    input logic signed [31:0] gxx, gyy, gxy, gyx, gzz,
    input pdi_pkg::pstate_t   st
  );
    logic signed [31:0] v;
    unique case (s)
      pdi_pkg::S_GXX:  v = gxx;
      pdi_pkg::S_GYY:  v = gyy;
      pdi_pkg::S_GXY:  v = gxy;
      pdi_pkg::S_GYX:  v = gyx;
      pdi_pkg::S_GZZ:  v = gzz;
      pdi_pkg::S_EXX:  v = st.exx;
      pdi_pkg::S_EYY:  v = st.eyy;
      pdi_pkg::S_EZZ:  v = st.ezz;
      pdi_pkg::S_EXY:  v = st.exy;
      pdi_pkg::S_WXY:  v = st.wxy;
      pdi_pkg::S_BXX:  v = st.bxx;
      pdi_pkg::S_BXY:  v = st.bxy;
      pdi_pkg::S_BYY:  v = st.byy;
      pdi_pkg::S_BZZ:  v = st.bzz;
      pdi_pkg::S_HALF: v = pdi_pkg::Q_HALF;
      pdi_pkg::S_ONE:  v = pdi_pkg::Q_ONE;
      default:         v = pdi_pkg::Q_ZERO;
    endcase
    return v;
  endfunction

  assign fa_nxt = fixed_src(uin.a.addr[3:0], gxx_r, gyy_r, gxy_r, gyx_r, gzz_r, st_rd_r);
  assign fb_nxt = fixed_src(uin.b.addr[3:0], gxx_r, gyy_r, gxy_r, gyx_r, gzz_r, st_rd_r);

  // ---------------------------------------------------------------------------
  // Shared saturating Q8.24 unit
  // ---------------------------------------------------------------------------
  assign opa      = sel_a_r ? ta_r : fa_r;
  assign opb      = sel_b_r ? tb_r : fb_r;
  assign prod     = 64'(opa) * 64'(opb);
  assign prod_rnd = prod + 64'sd8388608;      // round half up
  assign prod_q   = prod_rnd >>> 24;          // floor
  assign sum      = (op_r == pdi_pkg::OP_SUB) ? (33'(opa) - 33'(opb))
                                              : (33'(opa) + 33'(opb));

  always_comb begin
    case (op_r)
      pdi_pkg::OP_MUL: begin
        if (prod_q > 64'sd2147483647) begin
          res_nxt = 32'sh7fff_ffff;
        end else if (prod_q < -64'sd2147483648) begin
          res_nxt = 32'sh8000_0000;
        end else begin
          res_nxt = prod_q[31:0];
        end
      end
      default: begin
        if (sum[32] != sum[31]) begin
          res_nxt = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
          res_nxt = sum[31:0];
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == pdi_pkg::IDX_W'(pdi_pkg::PARTICLE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_OPRD;
      ST_OPRD:  state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_WRB;
      ST_WRB: begin
        state_nxt = (pc_r == pdi_pkg::PC_LAST) ? ST_STORE : ST_OPRD;
      end
      ST_STORE: state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_STORE);
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == ST_FETCH) begin
        pc_r <= '0;
      end else if (state_r == ST_WRB) begin
        pc_r <= pc_r + 1'b1;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      idx_r <= pdi_pkg::IDX_W'(in_particle_index % pdi_pkg::PARTICLE_COUNT);
      gxx_r <= in_grad_xx;
      gyy_r <= in_grad_yy;
      gxy_r <= in_grad_xy;
      gyx_r <= in_grad_yx;
      gzz_r <= in_grad_zz;
    end
  end

  // ---------------------------------------------------------------------------
  // State store: cleared after reset, read once and written once per request
  // ---------------------------------------------------------------------------
  always_comb begin
    st_clear     = '0;
    st_clear.bxx = pdi_pkg::Q_ONE;
    st_clear.byy = pdi_pkg::Q_ONE;
    st_clear.bzz = pdi_pkg::Q_ONE;
  end

  assign st_we    = (state_r == ST_CLEAR) || (state_r == ST_STORE);
  assign st_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : idx_r;
  assign st_wdata = (state_r == ST_CLEAR) ? st_clear
                  : pdi_pkg::pstate_t'{exx: nxx_r, eyy: nyy_r, ezz: nzz_r,
                                       exy: nxy_r, wxy: nwxy_r, bxx: nbxx_r,
                                       bxy: nbxy_r, byy: nbyy_r, bzz: nbzz_r};

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (state_r == ST_FETCH) begin
      st_rd_r <= st_mem[idx_r];
    end
  end

  // ---------------------------------------------------------------------------
  // Temporaries: operand read, execute, write back
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == ST_OPRD) begin
      ta_r    <= tmp_mem[uin.a.addr];
      tb_r    <= tmp_mem[uin.b.addr];
      fa_r    <= fa_nxt;
      fb_r    <= fb_nxt;
      sel_a_r <= uin.a.tmp;
      sel_b_r <= uin.b.tmp;
      op_r    <= uin.op;
    end
    if (state_r == ST_EXEC) begin
      res_r <= res_nxt;
    end
    if (state_r == ST_WRB) begin
      tmp_mem[pc_r] <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WRB) begin
      case (pc_r)
        pdi_pkg::T_NXX:  nxx_r  <= res_r;
        pdi_pkg::T_NYY:  nyy_r  <= res_r;
        pdi_pkg::T_NZZ:  nzz_r  <= res_r;
        pdi_pkg::T_NXY:  nxy_r  <= res_r;
        pdi_pkg::T_NWXY: nwxy_r <= res_r;
        pdi_pkg::T_NBXX: nbxx_r <= res_r;
        pdi_pkg::T_NBXY: nbxy_r <= res_r;
        pdi_pkg::T_NBYY: nbyy_r <= res_r;
        pdi_pkg::T_NBZZ: nbzz_r <= res_r;
        pdi_pkg::T_DET:  det_r  <= res_r;
        default: ;
      endcase
    end
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_new_strain_xx   = nxx_r;
  assign out_new_strain_yy   = nyy_r;
  assign out_new_strain_zz   = nzz_r;
  assign out_new_shear_xy    = nxy_r;
  assign out_new_rotation_xy = nwxy_r;
  assign out_new_b_xx        = nbxx_r;
  assign out_new_b_xy        = nbxy_r;
  assign out_new_b_yy        = nbyy_r;
  assign out_new_b_zz        = nbzz_r;
  assign out_increment_det   = det_r;

endmodule
